>>> hdl/column_binomial_blur_rgba8_top_assert.svh
// assertion helpers shared by the blur design
`ifndef COLUMN_BINOMIAL_BLUR_RGBA8_TOP_ASSERT_SVH
`define COLUMN_BINOMIAL_BLUR_RGBA8_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CBB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbb assertion failed");

// next-cycle implication, checked out of reset
`define CBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbb assertion failed");

`endif

>>> hdl/cbb_pkg.sv
`default_nettype none

package cbb_pkg;

    localparam int NUM_CHAN = 4;
    localparam int QUEUE_DEPTH = 3;
    localparam logic [1:0] CARRY_START = 2'd2;

    typedef struct packed {
        logic [7:0] chan0_in;
        logic [7:0] chan1_in;
        logic [7:0] chan2_in;
        logic [7:0] chan3_in;
        logic       column_end;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] chan0_out;
        logic [7:0] chan1_out;
        logic [7:0] chan2_out;
        logic [7:0] chan3_out;
        logic       column_done;
    } pix_out_t;

endpackage

`default_nettype wire

>>> hdl/cbb_chan.sv
`default_nettype none

module cbb_chan (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire logic       restart,
    input  wire logic       pass,
    input  wire logic [7:0] sample,
    output logic [7:0]      mid_result,
    output logic [7:0]      bot_result
);
    import cbb_pkg::*;

    logic [7:0] older_reg, older_next;
    logic [7:0] middle_reg, middle_next;
    logic [1:0] carry_reg, carry_next;
    logic [9:0] sum_mid;
    logic [9:0] sum_bot;

    // centre result uses the new sample as the one below
    assign sum_mid = 10'(older_reg) + {1'b0, middle_reg, 1'b0} + 10'(sample) + 10'(carry_reg);
    // bottom result replicates the new sample below itself
    assign sum_bot = 10'(middle_reg) + 10'(sample) + {1'b0, sample, 1'b0}
                   + 10'(sum_mid[1:0]);

    assign mid_result = pass ? middle_reg : sum_mid[9:2];
    assign bot_result = pass ? sample : sum_bot[9:2];

    always_comb
    begin
        older_next  = older_reg;
        middle_next = middle_reg;
        carry_next  = carry_reg;
        if (load)
        begin
            if (restart)
            begin
                older_next  = sample;
                middle_next = sample;
                carry_next  = CARRY_START;
            end
            else
            begin
                older_next  = middle_reg;
                middle_next = sample;
                carry_next  = sum_mid[1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg  <= '0;
            middle_reg <= '0;
            carry_reg  <= CARRY_START;
        end
        else
        begin
            older_reg  <= older_next;
            middle_reg <= middle_next;
            carry_reg  <= carry_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/column_binomial_blur_rgba8_top.sv
// a result word is queued for out when the input word that completes it is accepted
// throughput: one word per cycle unless stalled; the bottom pixel of a column adds a second
// result, so an n-pixel column (n > 1) yields n words; input stalls with two or more queued
// reset: no column in progress, carries at two, filter_channel_zero set, output queue empty
`default_nettype none
`include "column_binomial_blur_rgba8_top_assert.svh"

module column_binomial_blur_rgba8_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire cbb_pkg::pix_in_t in_word,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output cbb_pkg::pix_out_t     out_word
);
    import cbb_pkg::*;

    logic       filter_ch0_reg;
    logic       started_reg;
    logic [1:0] count_reg, count_next;
    pix_out_t   slot_reg [QUEUE_DEPTH];
    pix_out_t   slot_next [QUEUE_DEPTH];
    pix_out_t   shifted [QUEUE_DEPTH];

    logic       in_acc;
    logic       pop;
    logic [1:0] count_after;
    logic [1:0] push_n;
    pix_out_t   push0, push1;

    logic [7:0] px [NUM_CHAN];
    logic [7:0] mid_res [NUM_CHAN];
    logic [7:0] bot_res [NUM_CHAN];

    assign px[0] = in_word.chan0_in;
    assign px[1] = in_word.chan1_in;
    assign px[2] = in_word.chan2_in;
    assign px[3] = in_word.chan3_in;

    assign in_stall  = (count_reg > 2'd1);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign out_word  = slot_reg[0];

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_chan
        cbb_chan u_chan (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (in_acc),
            .restart    (!started_reg),
            .pass       ((c == 0) && !filter_ch0_reg),
            .sample     (px[c]),
            .mid_result (mid_res[c]),
            .bot_result (bot_res[c])
        );
    end

    // results caused by the accepted word
    always_comb
    begin
        push_n = 2'd0;
        push0  = '0;
        push1  = '0;
        if (in_acc)
        begin
            if (!started_reg)
            begin
                // one-pixel column passes straight through
                if (in_word.column_end)
                begin
                    push_n            = 2'd1;
                    push0.chan0_out   = px[0];
                    push0.chan1_out   = px[1];
                    push0.chan2_out   = px[2];
                    push0.chan3_out   = px[3];
                    push0.column_done = 1'b1;
                end
            end
            else
            begin
                push_n            = in_word.column_end ? 2'd2 : 2'd1;
                push0.chan0_out   = mid_res[0];
                push0.chan1_out   = mid_res[1];
                push0.chan2_out   = mid_res[2];
                push0.chan3_out   = mid_res[3];
                push0.column_done = 1'b0;
                push1.chan0_out   = bot_res[0];
                push1.chan1_out   = bot_res[1];
                push1.chan2_out   = bot_res[2];
                push1.chan3_out   = bot_res[3];
                push1.column_done = 1'b1;
            end
        end
    end

    // output queue: pop from slot 0, then append behind what is left
    always_comb
    begin
        shifted[0]  = pop ? slot_reg[1] : slot_reg[0];
        shifted[1]  = pop ? slot_reg[2] : slot_reg[1];
        shifted[2]  = slot_reg[2];
        count_after = count_reg - {1'b0, pop};
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_next[i] = shifted[i];
            if ((push_n != 2'd0) && (count_after == 2'(i)))
                slot_next[i] = push0;
            if ((push_n == 2'd2) && ((count_after + 2'd1) == 2'(i)))
                slot_next[i] = push1;
        end
        count_next = count_after + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_ch0_reg <= 1'b1;
            started_reg    <= 1'b0;
            count_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
                filter_ch0_reg <= cfg_wr_data;
            if (in_acc)
                started_reg <= !in_word.column_end;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            slot_reg[i] <= slot_next[i];
    end

    `CBB_ASSERT_NEXT(a_end_two_words, clk, rst_n,
        in_acc && started_reg && in_word.column_end && !pop,
        count_reg == $past(count_reg) + 2'd2)
    `CBB_ASSERT_NEXT(a_start_no_word, clk, rst_n,
        in_acc && !started_reg && !in_word.column_end && !pop,
        $stable(count_reg))
    `CBB_ASSERT_NOW(a_full_stalls, clk, rst_n,
        count_reg > 2'd1,
        in_stall)
    `CBB_ASSERT_NEXT(a_single_done, clk, rst_n,
        in_acc && !started_reg && in_word.column_end && count_reg == 2'd0,
        out_valid && out_word.column_done)

endmodule

`default_nettype wire
